[rtl/core/itrs_pkg.sv]
package itrs_pkg;

    // Bits of the input value that take part in the conversion.
    localparam int VALUE_WIDTH = 64;
    // Width of the value port itself.
    localparam int VALUE_PORT_W = 64;

    // Quotient bits produced per cycle by the long division.
    localparam int DIGIT_BITS = 4;
    localparam int STEPS = (VALUE_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PAD_W = STEPS * DIGIT_BITS;
    localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    // Digit stack: at most VALUE_WIDTH-1 digits for a saturated magnitude.
    localparam int DEPTH = VALUE_WIDTH;
    localparam int CNT_W = $clog2(DEPTH);

    localparam int RADIX_W = 6;
    localparam int CHAR_W = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2D);
    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(8'h41);

    localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // APB register map: one 32-bit register at byte address 0.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_WORD_RADIX = 1'b0;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_LIMIT) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else begin
            c = CHAR_ALPHA + CHAR_W'(d - DECIMAL_LIMIT);
        end
        return c;
    endfunction

endpackage

[rtl/core/integer_to_radix_string_unit.sv]
// Converts a signed integer into its text in the base held in the radix register
// (2 to 36; smaller values act as 2, larger ones as 36), one ASCII character per
// output transfer, most significant first, with last set on the final character.
// Negative values start with '-', digits above 9 are upper-case letters, and the
// most negative value prints as its neighbor one closer to zero. Each digit comes
// from a long division over the whole 64-bit value that retires 4 quotient bits
// per cycle; digits are stacked in a small memory and then read back one at a
// time through a read state and a load state, the load waiting while the output
// is stalled. For a negative value the minus sign is loaded before the first
// digit is read. A new value is taken only after the previous one has had its
// last character loaded for output.
module integer_to_radix_string_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [itrs_pkg::PADDR_W-1:0]           paddr,
    input  logic [itrs_pkg::PDATA_W-1:0]           pwdata,
    output logic [itrs_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [itrs_pkg::VALUE_PORT_W-1:0] value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [itrs_pkg::CHAR_W-1:0]            character,
    output logic                                   last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t                                 state_reg;
    logic                                   neg_reg;
    logic [itrs_pkg::RADIX_W-1:0]           base_reg;
    logic [itrs_pkg::PAD_W-1:0]             sh_reg;
    logic [itrs_pkg::RADIX_W-1:0]           rem_reg;
    logic [itrs_pkg::STEP_CNT_W-1:0]        step_reg;
    logic [itrs_pkg::CNT_W-1:0]             cnt_reg;
    logic                                   out_valid_reg;
    logic [itrs_pkg::CHAR_W-1:0]            character_reg;
    logic                                   last_reg;
    logic [itrs_pkg::RADIX_W-1:0]           radix_reg;
    logic [itrs_pkg::RADIX_W-1:0]           rd_data_reg;
    logic [itrs_pkg::RADIX_W-1:0]           mem [itrs_pkg::DEPTH];

    logic                                   reg_write;
    logic                                   reg_hit;
    logic [itrs_pkg::VALUE_WIDTH-1:0]       v_in;
    logic [itrs_pkg::VALUE_WIDTH-1:0]       v_neg;
    logic [itrs_pkg::VALUE_WIDTH-1:0]       mag;
    logic [itrs_pkg::RADIX_W-1:0]           base_eff;
    logic [itrs_pkg::RADIX_W-1:0]           rem_div;
    logic [itrs_pkg::DIGIT_BITS-1:0]        q_bits;
    logic [itrs_pkg::RADIX_W:0]             trial;
    logic [itrs_pkg::PAD_W-1:0]             sh_shift;
    logic                                   step_last;
    logic                                   mem_we;
    logic [itrs_pkg::CNT_W-1:0]             rd_addr;
    logic                                   slot_free;
    logic                                   last_digit;

    // Configuration port.
    assign pready = 1'b1;
    assign reg_hit = (paddr[itrs_pkg::PADDR_W-1] == itrs_pkg::REG_WORD_RADIX);
    assign reg_write = psel && penable && pwrite && reg_hit;

    always_comb
    begin
        prdata = '0;
        if (reg_hit)
        begin
            prdata[itrs_pkg::RADIX_W-1:0] = radix_reg;
        end
    end

    // Magnitude and effective base for a new value.
    assign v_in = value[itrs_pkg::VALUE_WIDTH-1:0];
    assign v_neg = ~v_in + itrs_pkg::VALUE_WIDTH'(1);

    always_comb
    begin
        if (!v_in[itrs_pkg::VALUE_WIDTH-1])
        begin
            mag = v_in;
        end
        else if (v_in == itrs_pkg::SIGN_BIT)
        begin
            mag = itrs_pkg::SIGN_BIT - itrs_pkg::VALUE_WIDTH'(1);
        end
        else
        begin
            mag = v_neg;
        end
    end

    always_comb
    begin
        if (radix_reg < itrs_pkg::RADIX_MIN)
        begin
            base_eff = itrs_pkg::RADIX_MIN;
        end
        else if (radix_reg > itrs_pkg::RADIX_MAX)
        begin
            base_eff = itrs_pkg::RADIX_MAX;
        end
        else
        begin
            base_eff = radix_reg;
        end
    end

    // Restoring division: each cycle shifts DIGIT_BITS dividend bits into the
    // remainder and the matching quotient bits into the bottom of the register.
    always_comb
    begin
        rem_div = rem_reg;
        q_bits = '0;
        trial = '0;
        for (int k = 0; k < itrs_pkg::DIGIT_BITS; k++)
        begin
            trial = {rem_div, sh_reg[itrs_pkg::PAD_W-1-k]};
            if (trial >= {1'b0, base_reg})
            begin
                rem_div = itrs_pkg::RADIX_W'(trial - {1'b0, base_reg});
                q_bits[itrs_pkg::DIGIT_BITS-1-k] = 1'b1;
            end
            else
            begin
                rem_div = trial[itrs_pkg::RADIX_W-1:0];
            end
        end
    end

    assign sh_shift = {sh_reg[itrs_pkg::PAD_W-itrs_pkg::DIGIT_BITS-1:0], q_bits};
    assign step_last = (step_reg == itrs_pkg::STEP_CNT_W'(itrs_pkg::STEPS - 1));
    assign mem_we = (state_reg == ST_DIV) && step_last;
    assign rd_addr = cnt_reg - itrs_pkg::CNT_W'(1);
    assign slot_free = !out_valid_reg || !out_stall;
    assign last_digit = (cnt_reg == itrs_pkg::CNT_W'(1));

    // Digit stack, least significant digit at address 0.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg] <= rem_div;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            neg_reg <= 1'b0;
            base_reg <= itrs_pkg::RADIX_RESET;
            sh_reg <= '0;
            rem_reg <= '0;
            step_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            character_reg <= '0;
            last_reg <= 1'b0;
            radix_reg <= itrs_pkg::RADIX_RESET;
        end
        else
        begin
            if (reg_write)
            begin
                radix_reg <= pwdata[itrs_pkg::RADIX_W-1:0];
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        neg_reg <= v_in[itrs_pkg::VALUE_WIDTH-1];
                        base_reg <= base_eff;
                        sh_reg <= itrs_pkg::PAD_W'(mag);
                        rem_reg <= '0;
                        step_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    sh_reg <= sh_shift;
                    if (step_last)
                    begin
                        // One digit done; the quotient is the next dividend.
                        cnt_reg <= cnt_reg + itrs_pkg::CNT_W'(1);
                        rem_reg <= '0;
                        step_reg <= '0;
                        if (sh_shift == '0)
                        begin
                            state_reg <= neg_reg ? ST_SIGN : ST_READ;
                        end
                    end
                    else
                    begin
                        rem_reg <= rem_div;
                        step_reg <= step_reg + itrs_pkg::STEP_CNT_W'(1);
                    end
                end
                ST_SIGN:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        character_reg <= itrs_pkg::CHAR_MINUS;
                        last_reg <= 1'b0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        character_reg <= itrs_pkg::digit_char(rd_data_reg);
                        last_reg <= last_digit;
                        cnt_reg <= rd_addr;
                        state_reg <= last_digit ? ST_IDLE : ST_READ;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last = last_reg;

`ifndef ASSERT_OFF
    // The working base is always clamped into the legal range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (base_reg >= itrs_pkg::RADIX_MIN &&
                                    base_reg <= itrs_pkg::RADIX_MAX))
        else $error("working base out of range");

    // A partial remainder never reaches the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < base_reg))
        else $error("division remainder not below base");

    // Every digit read back from the stack is a valid digit of the base.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (rd_data_reg < base_reg && cnt_reg != '0))
        else $error("digit stack read out of range");

    // A transfer marked last leaves the converter ready for the next value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && slot_free && last_digit) |=>
            (state_reg == ST_IDLE && out_valid_reg && last_reg))
        else $error("final character not flagged last");
`endif

endmodule
